// ----- rtl/core/ccacc_pkg.sv -----
// Shared types and constants for the collision centroid accumulator.
// Used by ccacc_table, ccacc_divider and collision_centroid_accumulator_core.
package ccacc_pkg;

   localparam int ENTRIES_DEFAULT = 16;
   localparam int MAX_REPORT      = 16;
   localparam int COORD_BITS      = 10;

   localparam int IDX_BITS   = 4;
   localparam int POS_BITS   = 10;
   localparam int OBJ_BITS   = 16;
   localparam int COUNT_BITS = 24;
   localparam int SUM_BITS   = 40;
   localparam int MEAN_BITS  = 10;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
   localparam logic [SUM_BITS-1:0]   SUM_MAX   = '1;

   // mean clamps to the coordinate range and to the output field
   localparam int COORD_LIMIT = (1 << COORD_BITS) - 1;
   localparam int FIELD_LIMIT = (1 << MEAN_BITS) - 1;
   localparam int MEAN_LIMIT  = (COORD_LIMIT < FIELD_LIMIT) ? COORD_LIMIT : FIELD_LIMIT;

   localparam logic [1:0] OP_FRAME_START = 2'd0;
   localparam logic [1:0] OP_SLICE       = 2'd1;
   localparam logic [1:0] OP_FRAME_END   = 2'd2;

   typedef struct packed {
      logic [1:0]          operation;
      logic [IDX_BITS-1:0] first_index;
      logic [IDX_BITS-1:0] second_index;
      logic [POS_BITS-1:0] row;
      logic [POS_BITS-1:0] span_start;
      logic [POS_BITS-1:0] span_end;
      logic [OBJ_BITS-1:0] first_object;
      logic [OBJ_BITS-1:0] second_object;
   } ccacc_req_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]   entry_index;
      logic [COUNT_BITS-1:0] pixel_count;
      logic [MEAN_BITS-1:0]  center_x;
      logic [MEAN_BITS-1:0]  center_y;
      logic [OBJ_BITS-1:0]   partner_object;
      logic                  last_entry;
   } ccacc_rsp_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic [SUM_BITS-1:0]   x_sum;
      logic [SUM_BITS-1:0]   y_sum;
      logic [OBJ_BITS-1:0]   partner;
   } ccacc_entry_type;

endpackage

// ----- rtl/core/ccacc_table.sv -----
// Entry table: one synchronous memory, registered read, with per-entry valid bits
// so a frame start clears the whole table at once. Depends on ccacc_pkg.
module ccacc_table #(
   parameter int ENTRIES = ccacc_pkg::ENTRIES_DEFAULT,
   parameter int AW      = $clog2(ENTRIES)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       clear,
   input  logic                       wr_en,
   input  logic [AW-1:0]              wr_addr,
   input  ccacc_pkg::ccacc_entry_type wr_data,
   input  logic [AW-1:0]              rd_addr,
   output ccacc_pkg::ccacc_entry_type rd_data
);
   import ccacc_pkg::*;

   ccacc_entry_type       mem_ff [ENTRIES];
   ccacc_entry_type       rd_data_ff;
   logic                  rd_valid_ff;
   logic [ENTRIES-1:0]    valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // an entry not written since the last clear reads as zero
   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

// ----- rtl/core/ccacc_divider.sv -----
// Restoring quotient unit: one quotient bit per cycle, eleven steps, clamped mean.
// Depends on ccacc_pkg.
module ccacc_divider (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic [ccacc_pkg::SUM_BITS-1:0]       dividend,
   input  logic [ccacc_pkg::COUNT_BITS-1:0]     divisor,
   output logic                                 done,
   output logic [ccacc_pkg::MEAN_BITS-1:0]      quotient
);
   import ccacc_pkg::*;

   // one extra quotient bit detects any mean beyond the field
   localparam int QBITS = MEAN_BITS + 1;
   localparam int DBITS = COUNT_BITS + MEAN_BITS;
   localparam int SBITS = $clog2(QBITS);

   logic [SUM_BITS-1:0] rem_ff;
   logic [DBITS-1:0]    dvs_ff;
   logic [QBITS-1:0]    q_ff;
   logic [SBITS-1:0]    step_ff;
   logic                run_ff;
   logic                done_ff;
   logic                zero_ff;
   logic                ge;

   assign ge = rem_ff >= SUM_BITS'(dvs_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            rem_ff  <= dividend;
            dvs_ff  <= {divisor, MEAN_BITS'(0)};
            q_ff    <= '0;
            step_ff <= SBITS'(QBITS - 1);
            zero_ff <= (divisor == '0);
            run_ff  <= 1'b1;
         end else if (run_ff) begin
            if (ge) begin
               rem_ff <= rem_ff - SUM_BITS'(dvs_ff);
            end
            q_ff   <= {q_ff[QBITS-2:0], ge};
            dvs_ff <= dvs_ff >> 1;
            if (step_ff == '0) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               step_ff <= step_ff - 1'b1;
            end
         end
      end
   end

   assign done = done_ff;

   always_comb begin
      if (zero_ff) begin
         quotient = '0;
      end else if (32'(q_ff) > MEAN_LIMIT) begin
         quotient = MEAN_BITS'(MEAN_LIMIT);
      end else begin
         quotient = q_ff[MEAN_BITS-1:0];
      end
   end

endmodule

// ----- rtl/core/collision_centroid_accumulator_core.sv -----
// Collision centroid accumulator top level: request decode, slice update sequencer
// and frame-end report walker. Depends on ccacc_pkg, ccacc_table, ccacc_divider.
//
// A request transfers when start is high and busy is low. Frame start clears the
// table at once. A slice forms the span terms, then reads each of the two entries
// from the table memory and writes it back in turn, so the second update always
// sees the first. Frame end emits one result per entry for min(ENTRIES, 16)
// entries, each mean formed by an eleven-step quotient unit; rsp_strobe marks each
// result for exactly one cycle, and the receiver cannot stall the report.
// Operation 3 is accepted and ignored.
module collision_centroid_accumulator_core #(
   parameter int ENTRIES = ccacc_pkg::ENTRIES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  ccacc_pkg::ccacc_req_type req_data,
   output logic                     rsp_strobe,
   output ccacc_pkg::ccacc_rsp_type rsp_data
);
   import ccacc_pkg::*;

   localparam int AW  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int RPT = (ENTRIES < MAX_REPORT) ? ENTRIES : MAX_REPORT;
   localparam int RW  = (RPT > 1) ? $clog2(RPT) : 1;
   localparam int DX_BITS = 2 * POS_BITS + 1;
   localparam int DY_BITS = 2 * POS_BITS;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PROD,
      ST_MOD1,
      ST_RD2,
      ST_MOD2,
      ST_RP_READ,
      ST_RP_LOAD,
      ST_RP_DIV
   } state_type;

   state_type             state_ff;
   ccacc_req_type         req_ff;
   logic [POS_BITS-1:0]   len_ff;
   logic [DX_BITS-1:0]    dx_ff;
   logic [DY_BITS-1:0]    dy_ff;
   logic [RW-1:0]         cnt_ff;
   logic [COUNT_BITS-1:0] rp_count_ff;
   logic [OBJ_BITS-1:0]   rp_partner_ff;
   logic                  rsp_strobe_ff;
   ccacc_rsp_type         rsp_data_ff;

   logic                  accept;
   logic                  clear;
   logic [POS_BITS-1:0]   len_in;
   logic [DX_BITS-1:0]    dx_in;
   logic [DY_BITS-1:0]    dy_in;
   logic                  first_ok;
   logic                  second_ok;
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   ccacc_entry_type       wr_data;
   logic [AW-1:0]         rd_addr;
   ccacc_entry_type       rd_data;
   logic [OBJ_BITS-1:0]   partner_in;
   logic [COUNT_BITS:0]   count_sum;
   logic [SUM_BITS:0]     x_sum;
   logic [SUM_BITS:0]     y_sum;
   logic                  div_start;
   logic                  x_done;
   logic                  y_done;
   logic [MEAN_BITS-1:0]  x_mean;
   logic [MEAN_BITS-1:0]  y_mean;
   logic                  last;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;
   assign clear  = accept && (req_data.operation == OP_FRAME_START);

   // span terms; a reversed or empty span has zero length
   always_comb begin
      logic [DX_BITS-1:0] tri_sum;
      len_in  = (req_ff.span_end > req_ff.span_start) ?
                (req_ff.span_end - req_ff.span_start) : '0;
      tri_sum = DX_BITS'(len_in) * (DX_BITS'(len_in) + 1'b1);
      dx_in   = DX_BITS'(req_ff.span_start) * DX_BITS'(len_in) + (tri_sum >> 1);
      dy_in   = DY_BITS'(len_in) * DY_BITS'(req_ff.row);
   end

   assign first_ok  = 32'(req_ff.first_index) < 32'(ENTRIES);
   assign second_ok = 32'(req_ff.second_index) < 32'(ENTRIES);

   always_comb begin
      unique case (state_ff)
         ST_PROD:    rd_addr = AW'(req_ff.first_index);
         ST_RD2:     rd_addr = AW'(req_ff.second_index);
         default:    rd_addr = AW'(cnt_ff);
      endcase
   end

   // read-modify-write of one entry with saturating accumulators
   assign count_sum  = {1'b0, rd_data.count} + (COUNT_BITS + 1)'(len_ff);
   assign x_sum      = {1'b0, rd_data.x_sum} + (SUM_BITS + 1)'(dx_ff);
   assign y_sum      = {1'b0, rd_data.y_sum} + (SUM_BITS + 1)'(dy_ff);
   assign partner_in = (state_ff == ST_MOD1) ? req_ff.second_object : req_ff.first_object;
   assign wr_en      = ((state_ff == ST_MOD1) && first_ok) ||
                       ((state_ff == ST_MOD2) && second_ok);
   assign wr_addr    = (state_ff == ST_MOD1) ? AW'(req_ff.first_index) :
                                              AW'(req_ff.second_index);

   always_comb begin
      wr_data.count   = count_sum[COUNT_BITS] ? COUNT_MAX : count_sum[COUNT_BITS-1:0];
      wr_data.x_sum   = x_sum[SUM_BITS] ? SUM_MAX : x_sum[SUM_BITS-1:0];
      wr_data.y_sum   = y_sum[SUM_BITS] ? SUM_MAX : y_sum[SUM_BITS-1:0];
      wr_data.partner = partner_in;
   end

   assign div_start = (state_ff == ST_RP_LOAD);
   assign last      = (cnt_ff == RW'(RPT - 1));

   ccacc_table #(
      .ENTRIES (ENTRIES),
      .AW      (AW)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .clear   (clear),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   ccacc_divider u_div_x (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data.x_sum),
      .divisor  (rd_data.count),
      .done     (x_done),
      .quotient (x_mean)
   );

   ccacc_divider u_div_y (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (rd_data.y_sum),
      .divisor  (rd_data.count),
      .done     (y_done),
      .quotient (y_mean)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_strobe_ff <= 1'b0;
         cnt_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  req_ff <= req_data;
                  cnt_ff <= '0;
                  if (req_data.operation == OP_SLICE) begin
                     state_ff <= ST_PROD;
                  end else if (req_data.operation == OP_FRAME_END) begin
                     state_ff <= ST_RP_READ;
                  end
               end
            end
            ST_PROD: begin
               len_ff   <= len_in;
               dx_ff    <= dx_in;
               dy_ff    <= dy_in;
               state_ff <= ST_MOD1;
            end
            ST_MOD1: begin
               state_ff <= ST_RD2;
            end
            ST_RD2: begin
               state_ff <= ST_MOD2;
            end
            ST_MOD2: begin
               state_ff <= ST_IDLE;
            end
            ST_RP_READ: begin
               state_ff <= ST_RP_LOAD;
            end
            ST_RP_LOAD: begin
               rp_count_ff   <= rd_data.count;
               rp_partner_ff <= rd_data.partner;
               state_ff      <= ST_RP_DIV;
            end
            ST_RP_DIV: begin
               if (x_done && y_done) begin
                  rsp_strobe_ff              <= 1'b1;
                  rsp_data_ff.entry_index    <= IDX_BITS'(cnt_ff);
                  rsp_data_ff.pixel_count    <= rp_count_ff;
                  rsp_data_ff.center_x       <= x_mean;
                  rsp_data_ff.center_y       <= y_mean;
                  rsp_data_ff.partner_object <= rp_partner_ff;
                  rsp_data_ff.last_entry     <= last;
                  if (last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     cnt_ff   <= cnt_ff + 1'b1;
                     state_ff <= ST_RP_READ;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Testbench for collision_centroid_accumulator_core: directed and random command
// streams checked against an in-bench model of the collision entry table.
// Depends on ccacc_pkg and the core RTL.
module testbench;
   import ccacc_pkg::*;

   localparam int REPORT_LEN = (ENTRIES_DEFAULT < MAX_REPORT) ? ENTRIES_DEFAULT : MAX_REPORT;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int SETTLE_CYCLES = 64;

   logic          clock    = 1'b0;
   logic          reset    = 1'b1;
   logic          start    = 1'b0;
   ccacc_req_type req_data = '0;
   logic          busy;
   logic          rsp_strobe;
   ccacc_rsp_type rsp_data;

   collision_centroid_accumulator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // model of the entry table
   logic [COUNT_BITS-1:0] tbl_count   [ENTRIES_DEFAULT];
   logic [SUM_BITS-1:0]   tbl_xsum    [ENTRIES_DEFAULT];
   logic [SUM_BITS-1:0]   tbl_ysum    [ENTRIES_DEFAULT];
   logic [OBJ_BITS-1:0]   tbl_partner [ENTRIES_DEFAULT];

   ccacc_rsp_type pending_reports[$];

   int error_count      = 0;
   int commands_sent    = 0;
   int entries_checked  = 0;
   int frames_reported  = 0;
   int sender_idle_pct  = 0;

   task automatic report_error(input string what, input logic [63:0] got,
                               input logic [63:0] want);
      $display("ERROR %0t ns: %s got %0h want %0h", $time, what, got, want);
      error_count++;
   endtask

   function automatic longint unsigned clip_add(input longint unsigned a,
                                                input longint unsigned b,
                                                input longint unsigned ceiling);
      longint unsigned s;
      s = a + b;
      return (s > ceiling) ? ceiling : s;
   endfunction

   function automatic logic [MEAN_BITS-1:0] mean_or_zero(input longint unsigned total,
                                                         input longint unsigned n);
      longint unsigned m;
      if (n == 0) return '0;
      m = total / n;
      if (m > 64'(MEAN_LIMIT)) m = 64'(MEAN_LIMIT);
      return m[MEAN_BITS-1:0];
   endfunction

   function automatic void clear_table();
      foreach (tbl_count[i]) begin
         tbl_count[i]   = '0;
         tbl_xsum[i]    = '0;
         tbl_ysum[i]    = '0;
         tbl_partner[i] = '0;
      end
   endfunction

   function automatic void add_overlap(input int idx, input longint unsigned len,
                                       input longint unsigned dx, input longint unsigned dy,
                                       input logic [OBJ_BITS-1:0] partner);
      if (idx >= ENTRIES_DEFAULT) return;
      tbl_count[idx]   = COUNT_BITS'(clip_add(64'(tbl_count[idx]), len, 64'(COUNT_MAX)));
      tbl_xsum[idx]    = SUM_BITS'(clip_add(64'(tbl_xsum[idx]), dx, 64'(SUM_MAX)));
      tbl_ysum[idx]    = SUM_BITS'(clip_add(64'(tbl_ysum[idx]), dy, 64'(SUM_MAX)));
      tbl_partner[idx] = partner;
   endfunction

   // apply one accepted command to the table model; a frame end queues its report
   function automatic void apply_command(input ccacc_req_type item);
      longint unsigned len, xs, xe, dx, dy;
      ccacc_rsp_type   r;
      case (item.operation)
         OP_FRAME_START: clear_table();
         OP_SLICE: begin
            xs  = 64'(item.span_start);
            xe  = 64'(item.span_end);
            len = (xe > xs) ? xe - xs : '0;
            dx  = xs * len + (len * (len + 1)) / 2;
            dy  = len * 64'(item.row);
            add_overlap(int'(item.first_index), len, dx, dy, item.second_object);
            add_overlap(int'(item.second_index), len, dx, dy, item.first_object);
         end
         OP_FRAME_END: begin
            for (int k = 0; k < REPORT_LEN; k++) begin
               r.entry_index    = k[IDX_BITS-1:0];
               r.pixel_count    = tbl_count[k];
               r.center_x       = mean_or_zero(64'(tbl_xsum[k]), 64'(tbl_count[k]));
               r.center_y       = mean_or_zero(64'(tbl_ysum[k]), 64'(tbl_count[k]));
               r.partner_object = tbl_partner[k];
               r.last_entry     = (k == REPORT_LEN - 1);
               pending_reports.push_back(r);
            end
            frames_reported++;
         end
         default: ;
      endcase
   endfunction

   // one command transfer; start is left high so a following command can go back to back
   task automatic send_item(input ccacc_req_type item);
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy !== 1'b0);
      apply_command(item);
      commands_sent++;
   endtask

   task automatic wait_for_reports();
      start <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string name, input int idx, input logic [63:0] got,
                              input logic [63:0] want);
      if (got !== want) report_error($sformatf("entry %0d %s", idx, name), got, want);
   endtask

   always @(posedge clock) begin
      ccacc_rsp_type want;
      if (!reset && rsp_strobe === 1'b1) begin
         if (pending_reports.size() == 0) begin
            report_error("result with no report pending", 64'(rsp_data.entry_index),
                         64'(0));
         end else begin
            want = pending_reports.pop_front();
            check_field("entry_index", int'(want.entry_index),
                        64'(rsp_data.entry_index), 64'(want.entry_index));
            check_field("pixel_count", int'(want.entry_index),
                        64'(rsp_data.pixel_count), 64'(want.pixel_count));
            check_field("center_x", int'(want.entry_index), 64'(rsp_data.center_x),
                        64'(want.center_x));
            check_field("center_y", int'(want.entry_index), 64'(rsp_data.center_y),
                        64'(want.center_y));
            check_field("partner_object", int'(want.entry_index),
                        64'(rsp_data.partner_object), 64'(want.partner_object));
            check_field("last_entry", int'(want.entry_index), 64'(rsp_data.last_entry),
                        64'(want.last_entry));
            entries_checked++;
         end
      end
   end

   function automatic ccacc_req_type make_slice(input int a, input int b, input int row,
                                                input int xs, input int xe,
                                                input int obj_a, input int obj_b);
      ccacc_req_type item;
      item.operation     = OP_SLICE;
      item.first_index   = a[IDX_BITS-1:0];
      item.second_index  = b[IDX_BITS-1:0];
      item.row           = row[POS_BITS-1:0];
      item.span_start    = xs[POS_BITS-1:0];
      item.span_end      = xe[POS_BITS-1:0];
      item.first_object  = obj_a[OBJ_BITS-1:0];
      item.second_object = obj_b[OBJ_BITS-1:0];
      return item;
   endfunction

   function automatic ccacc_req_type random_slice();
      int a, b, xs, xe;
      a = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
      b = $urandom_range(1) ? $urandom_range(3) : $urandom_range(15);
      xs = $urandom_range(1023);
      case ($urandom_range(9))
         0, 1, 2, 3, 4: xe = xs + $urandom_range(1023 - xs);
         5, 6:          xe = (xs + $urandom_range(8) > 1023) ? 1023 : xs + $urandom_range(8);
         7:             xe = (xs == 0) ? 0 : $urandom_range(xs - 1);   // reversed
         8:             xe = xs;
         default:       xe = $urandom_range(1023);
      endcase
      return make_slice(a, b, $urandom_range(1023), xs, xe, $urandom_range(16'hFFFF),
                        $urandom_range(16'hFFFF));
   endfunction

   // frame commands carry random payload, which the block must ignore
   function automatic ccacc_req_type frame_cmd(input logic [1:0] op);
      ccacc_req_type item;
      item           = random_slice();
      item.operation = op;
      return item;
   endfunction

   task automatic run_random_frames(input int idle_pct, input int target);
      int first, kind;
      sender_idle_pct = idle_pct;
      first = commands_sent;
      while (commands_sent - first < target) begin
         kind = $urandom_range(9);
         if (kind <= 6) begin
            // well-formed frame; sometimes without the clear so entries build up
            if ($urandom_range(4) != 0) send_item(frame_cmd(OP_FRAME_START));
            repeat ($urandom_range(1, 12)) send_item(random_slice());
            send_item(frame_cmd(OP_FRAME_END));
         end else if (kind == 7) begin
            // cut-off frame, no report
            repeat ($urandom_range(1, 5)) send_item(random_slice());
         end else begin
            case ($urandom_range(2))
               0:       send_item(frame_cmd(OP_UNUSED));
               1:       send_item(frame_cmd(OP_FRAME_END));
               default: send_item(frame_cmd(OP_FRAME_START));
            endcase
         end
      end
      wait_for_reports();
   endtask

   task automatic test_directed_cases();
      ccacc_req_type item;
      sender_idle_pct = 13;
      send_item(frame_cmd(OP_FRAME_START));
      send_item(frame_cmd(OP_FRAME_END));                     // cleared table
      send_item(make_slice(0, 15, 1023, 0, 1023, 16'hFFFF, 16'h0000));
      send_item(make_slice(15, 0, 0, 1022, 1023, 16'h0000, 16'hFFFF));
      send_item(make_slice(5, 6, 700, 600, 100, 16'hA5A5, 16'h5A5A));   // reversed span
      send_item(make_slice(7, 8, 300, 300, 300, 16'h0F0F, 16'hF0F0));   // empty span
      send_item(make_slice(9, 9, 512, 10, 20, 16'h1234, 16'h5678));     // same entry
      send_item(make_slice(10, 3, 1, 0, 1, 16'h0001, 16'h8000));
      item = '1;
      item.operation = OP_UNUSED;
      send_item(item);
      send_item(frame_cmd(OP_FRAME_END));
      send_item(frame_cmd(OP_FRAME_END));                     // repeat gives same values
      send_item(make_slice(12, 11, 1023, 1023, 0, 16'hFFFF, 16'hFFFF));
      send_item(make_slice(15, 15, 1023, 0, 1023, 16'hFFFF, 16'hFFFF));
      send_item(frame_cmd(OP_FRAME_END));
      send_item(frame_cmd(OP_FRAME_START));
      send_item(frame_cmd(OP_FRAME_END));
      wait_for_reports();
   endtask

   task automatic test_light_sender_idle();
      run_random_frames(13, 130);
   endtask

   task automatic test_heavy_sender_idle();
      run_random_frames(55, 130);
   endtask

   task automatic test_back_to_back();
      run_random_frames(0, 130);
   endtask

   initial begin
      // the table is all zero out of reset
      clear_table();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      test_directed_cases();
      test_light_sender_idle();
      test_heavy_sender_idle();
      test_back_to_back();
      wait_for_reports();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_reports.size() != 0)
         report_error("reports never received", 64'(pending_reports.size()), 64'(0));
      $display("Run covered %0d commands (directed, then sender idle 13%%, 55%%, none);",
               commands_sent);
      $display("%0d frame reports with %0d entries compared, %0d mismatches.",
               frames_reported, entries_checked, error_count);
      if (error_count == 0) begin
         $display("PASS collision_centroid_accumulator_core");
      end else begin
         $display("FAIL collision_centroid_accumulator_core");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timeout with %0d reports pending", pending_reports.size());
      $display("FAIL collision_centroid_accumulator_core");
      $finish;
   end

endmodule
